@@ hdl/nsbe_pkg.sv @@
package nsbe_pkg;

    localparam int WORD_W  = 32;
    localparam int NWORDS  = 4;
    localparam int CFG_W   = 64;
    localparam int IDX_W   = 3;
    localparam int ROUND_W = 8;

    localparam logic [ROUND_W-1:0] ROUNDS_RESET = 8'd8;

    localparam logic [WORD_W-1:0] NIB_LO1 = 32'h7777_7777;
    localparam logic [WORD_W-1:0] NIB_HI1 = 32'h8888_8888;
    localparam logic [WORD_W-1:0] NIB_LO2 = 32'h3333_3333;
    localparam logic [WORD_W-1:0] NIB_HI2 = 32'hCCCC_CCCC;

    localparam logic [IDX_W-1:0] REG_KEY_LOW    = 3'd0;
    localparam logic [IDX_W-1:0] REG_KEY_HIGH   = 3'd1;
    localparam logic [IDX_W-1:0] REG_CONST_LOW  = 3'd2;
    localparam logic [IDX_W-1:0] REG_CONST_HIGH = 3'd3;
    localparam logic [IDX_W-1:0] REG_ROUNDS     = 3'd4;

    typedef logic [NWORDS-1:0][WORD_W-1:0] blk_t;

    typedef struct packed {
        logic [31:0] in_word3;
        logic [31:0] in_word2;
        logic [31:0] in_word1;
        logic [31:0] in_word0;
    } in_item_t;

    typedef struct packed {
        logic [31:0] out_word3;
        logic [31:0] out_word2;
        logic [31:0] out_word1;
        logic [31:0] out_word0;
    } out_item_t;

    typedef struct packed {
        blk_t               round_key;
        logic [ROUND_W-1:0] rounds;
    } cfg_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    function automatic logic [3:0] sbox(input logic [3:0] x);
        logic [3:0] r;
        case (x)
            4'h0: r = 4'd8;
            4'h1: r = 4'd2;
            4'h2: r = 4'd4;
            4'h3: r = 4'd0;
            4'h4: r = 4'd15;
            4'h5: r = 4'd5;
            4'h6: r = 4'd7;
            4'h7: r = 4'd12;
            4'h8: r = 4'd10;
            4'h9: r = 4'd6;
            4'hA: r = 4'd11;
            4'hB: r = 4'd3;
            4'hC: r = 4'd14;
            4'hD: r = 4'd13;
            4'hE: r = 4'd9;
            4'hF: r = 4'd1;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/nsbe_cfg.sv @@
module nsbe_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [nsbe_pkg::IDX_W-1:0]  cfg_index,
    input  logic [nsbe_pkg::CFG_W-1:0]  cfg_wdata,
    output nsbe_pkg::cfg_t              cfg
);

    logic [nsbe_pkg::CFG_W-1:0]   key_low_reg, key_high_reg;
    logic [nsbe_pkg::CFG_W-1:0]   const_low_reg, const_high_reg;
    logic [nsbe_pkg::ROUND_W-1:0] rounds_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            const_low_reg  <= '0;
            const_high_reg <= '0;
            rounds_reg     <= nsbe_pkg::ROUNDS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nsbe_pkg::REG_KEY_LOW:    key_low_reg    <= cfg_wdata;
                nsbe_pkg::REG_KEY_HIGH:   key_high_reg   <= cfg_wdata;
                nsbe_pkg::REG_CONST_LOW:  const_low_reg  <= cfg_wdata;
                nsbe_pkg::REG_CONST_HIGH: const_high_reg <= cfg_wdata;
                nsbe_pkg::REG_ROUNDS:     rounds_reg     <= cfg_wdata[nsbe_pkg::ROUND_W-1:0];
                default: ;
            endcase
        end
    end

    // constant and key fold into one round key
    assign cfg.round_key = {key_high_reg ^ const_high_reg, key_low_reg ^ const_low_reg};
    assign cfg.rounds    = rounds_reg;

endmodule

@@ hdl/nsbe_round.sv @@
module nsbe_round (
    input  nsbe_pkg::blk_t state_in,
    input  nsbe_pkg::blk_t round_key,
    output nsbe_pkg::blk_t state_out
);

    nsbe_pkg::blk_t sub, rot, r1, r2;

    always_comb
    begin
        for (int i = 0; i < nsbe_pkg::NWORDS; i++)
        begin
            for (int k = 0; k < 8; k++)
            begin
                sub[i][4*k +: 4] = nsbe_pkg::sbox(state_in[i][4*k +: 4]);
            end
        end
        rot[0] = sub[0];
        rot[1] = {sub[1][27:0], sub[1][31:28]};
        rot[2] = {sub[2][23:0], sub[2][31:24]};
        rot[3] = {sub[3][19:0], sub[3][31:20]};
        for (int i = 0; i < nsbe_pkg::NWORDS; i++)
        begin
            r1[i] = ((rot[i] & nsbe_pkg::NIB_LO1) << 1) | ((rot[i] & nsbe_pkg::NIB_HI1) >> 3);
            r2[i] = ((rot[i] & nsbe_pkg::NIB_LO2) << 2) | ((rot[i] & nsbe_pkg::NIB_HI2) >> 2);
        end
        for (int i = 0; i < nsbe_pkg::NWORDS; i++)
        begin
            state_out[i] = rot[2'(i + 1)] ^ r1[2'(i + 2)] ^ r2[2'(i + 3)] ^ round_key[i];
        end
    end

endmodule

@@ hdl/nibble_spn_block_encrypt.sv @@
// channel | direction | handshake               | payload
// in      | in        | in_valid / in_ready     | in_data   (in_item_t)
// out     | out       | out_valid / out_ready   | out_data  (out_item_t)
// cfg     | in        | cfg_we                  | cfg_index, cfg_wdata
//
// After an item is accepted it takes round_count passes of the shared round
// unit, one per cycle, then a transfer into the output register once it is free.
// in_ready is low from acceptance until the transfer and rises the cycle after,
// so no new item is taken until the last one has moved to the output register;
// the output register lets the next item start while a result waits.
// A stalled output holds the finished block in the working register.
// Asynchronous active-low reset clears control and configuration.
module nibble_spn_block_encrypt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  nsbe_pkg::in_item_t          in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output nsbe_pkg::out_item_t         out_data,
    input  logic                        cfg_we,
    input  logic [nsbe_pkg::IDX_W-1:0]  cfg_index,
    input  logic [nsbe_pkg::CFG_W-1:0]  cfg_wdata
);

    nsbe_pkg::cfg_t   cfg;
    nsbe_pkg::state_t state_reg, state_next;
    nsbe_pkg::blk_t   blk_reg, blk_next, blk_round;
    nsbe_pkg::blk_t   out_reg, out_next;
    logic [nsbe_pkg::ROUND_W-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;
    logic accept, out_free, transfer;

    nsbe_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    nsbe_round u_round (
        .state_in  (blk_reg),
        .round_key (cfg.round_key),
        .state_out (blk_round)
    );

    assign in_ready = (state_reg == nsbe_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        blk_next       = blk_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        transfer       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            nsbe_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    blk_next   = nsbe_pkg::blk_t'(in_data);
                    cnt_next   = cfg.rounds;
                    state_next = nsbe_pkg::ST_RUN;
                end
            end
            nsbe_pkg::ST_RUN:
            begin
                if (cnt_reg != '0)
                begin
                    blk_next = blk_round;
                    cnt_next = cnt_reg - 1'b1;
                end
                else if (out_free)
                begin
                    transfer       = 1'b1;
                    out_next       = blk_reg;
                    out_valid_next = 1'b1;
                    state_next     = nsbe_pkg::ST_IDLE;
                end
            end
            default: state_next = nsbe_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nsbe_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        if (transfer)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = nsbe_pkg::out_item_t'(out_reg);

endmodule

@@ hdl/nsbe_checker.sv @@
module nsbe_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input nsbe_pkg::out_item_t        out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result item dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after an accepted item");

    a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result shown while block still busy");

    a_result_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without an item in flight");

endmodule

bind nibble_spn_block_encrypt nsbe_checker u_nsbe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

@@ tb/sv/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 300;
    // substitution table, entry n in bits 4n+3:4n
    localparam logic [63:0] SUBST = 64'h19DE_3B6A_C75F_0428;

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               in_valid  = 1'b0;
    logic                               in_ready;
    nsbe_pkg::in_item_t                 in_data   = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    nsbe_pkg::out_item_t                out_data;
    logic                               cfg_we    = 1'b0;
    logic [nsbe_pkg::IDX_W-1:0]         cfg_index = '0;
    logic [nsbe_pkg::CFG_W-1:0]         cfg_wdata = '0;

    logic [63:0]                        key_lo    = '0;
    logic [63:0]                        key_hi    = '0;
    logic [63:0]                        rc_lo     = '0;
    logic [63:0]                        rc_hi     = '0;
    logic [nsbe_pkg::ROUND_W-1:0]       n_rounds  = nsbe_pkg::ROUNDS_RESET;

    nsbe_pkg::in_item_t                 pending_blocks[$];
    nsbe_pkg::out_item_t                expected_cipher[$];
    int                                 err_count   = 0;
    int                                 result_idx  = 0;
    int                                 tx_gap      = 0;
    int                                 rx_gap      = 0;
    int                                 idle_cycles = 0;
    bit                                 tx_burst    = 1'b0;
    bit                                 rx_burst    = 1'b0;

    nibble_spn_block_encrypt u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [31:0] subst_word(input logic [31:0] x);
        logic [31:0] r;
        int k;
        for (k = 0; k < 8; k++)
            r[4*k +: 4] = SUBST[{x[4*k +: 4], 2'b00} +: 4];
        return r;
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (nsbe_pkg::WORD_W - n));
    endfunction

    function automatic logic [31:0] nib_rot1(input logic [31:0] x);
        return ((x & nsbe_pkg::NIB_LO1) << 1) | ((x & nsbe_pkg::NIB_HI1) >> 3);
    endfunction

    function automatic logic [31:0] nib_rot2(input logic [31:0] x);
        return ((x & nsbe_pkg::NIB_LO2) << 2) | ((x & nsbe_pkg::NIB_HI2) >> 2);
    endfunction

    function automatic nsbe_pkg::out_item_t spn_encrypt(input nsbe_pkg::in_item_t blk);
        logic [31:0]         w [nsbe_pkg::NWORDS];
        logic [31:0]         t [nsbe_pkg::NWORDS];
        logic [127:0]        kw;
        logic [127:0]        rc;
        nsbe_pkg::out_item_t r;
        int                  n;
        int                  i;
        w[0] = blk.in_word0;
        w[1] = blk.in_word1;
        w[2] = blk.in_word2;
        w[3] = blk.in_word3;
        kw = {key_hi, key_lo};
        rc = {rc_hi, rc_lo};
        for (n = 0; n < n_rounds; n++)
        begin
            for (i = 0; i < nsbe_pkg::NWORDS; i++)
                w[i] = subst_word(w[i]);
            w[1] = rotl(w[1], 4);
            w[2] = rotl(w[2], 8);
            w[3] = rotl(w[3], 12);
            for (i = 0; i < nsbe_pkg::NWORDS; i++)
                t[i] = w[(i + 1) % nsbe_pkg::NWORDS] ^ nib_rot1(w[(i + 2) % nsbe_pkg::NWORDS])
                       ^ nib_rot2(w[(i + 3) % nsbe_pkg::NWORDS]);
            for (i = 0; i < nsbe_pkg::NWORDS; i++)
                w[i] = t[i] ^ rc[32*i +: 32] ^ kw[32*i +: 32];
        end
        r.out_word0 = w[0];
        r.out_word1 = w[1];
        r.out_word2 = w[2];
        r.out_word3 = w[3];
        return r;
    endfunction

    function automatic int pick_gap(input bit burst);
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] rand_reg();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void queue_block(input logic [31:0] w0, input logic [31:0] w1,
                                        input logic [31:0] w2, input logic [31:0] w3);
        nsbe_pkg::in_item_t b;
        b.in_word0 = w0;
        b.in_word1 = w1;
        b.in_word2 = w2;
        b.in_word3 = w3;
        pending_blocks.push_back(b);
    endfunction

    function automatic void queue_random(input int count);
        int k;
        for (k = 0; k < count; k++)
            queue_block(rand_word(), rand_word(), rand_word(), rand_word());
    endfunction

    task automatic report(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_word(input string field, input logic [31:0] got,
                              input logic [31:0] want);
        if (got !== want)
            report($sformatf("item %0d %s: got %h, expected %h", result_idx, field, got, want));
    endtask

    // one write per clock; keeps the local copy of the registers in step
    task automatic write_reg(input logic [nsbe_pkg::IDX_W-1:0] idx,
                             input logic [nsbe_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            nsbe_pkg::REG_KEY_LOW:    key_lo   = val;
            nsbe_pkg::REG_KEY_HIGH:   key_hi   = val;
            nsbe_pkg::REG_CONST_LOW:  rc_lo    = val;
            nsbe_pkg::REG_CONST_HIGH: rc_hi    = val;
            nsbe_pkg::REG_ROUNDS:     n_rounds = val[nsbe_pkg::ROUND_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_blocks.size() != 0 || in_valid || expected_cipher.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            tx_gap   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_cipher.push_back(spn_encrypt(in_data));
            if (!in_valid || in_ready)
            begin
                if (tx_gap > 0)
                begin
                    in_valid <= 1'b0;
                    tx_gap   <= tx_gap - 1;
                end
                else if (pending_blocks.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_blocks.pop_front();
                    tx_gap   <= pick_gap(tx_burst);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_check
        nsbe_pkg::out_item_t want;
        int                  n;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_gap    <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_cipher.size() == 0)
                    report($sformatf("item %0d: result with no block outstanding", result_idx));
                else
                begin
                    want = expected_cipher.pop_front();
                    check_word("out_word0", out_data.out_word0, want.out_word0);
                    check_word("out_word1", out_data.out_word1, want.out_word1);
                    check_word("out_word2", out_data.out_word2, want.out_word2);
                    check_word("out_word3", out_data.out_word3, want.out_word3);
                end
                result_idx <= result_idx + 1;
            end
            if (rx_gap > 0)
            begin
                out_ready <= 1'b0;
                rx_gap    <= rx_gap - 1;
            end
            else if (out_valid && out_ready)
            begin
                n = pick_gap(rx_burst);
                out_ready <= (n == 0);
                rx_gap    <= n;
            end
            else
                out_ready <= rx_burst || ($urandom_range(0, 9) != 0);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        int          p;
        int          k;
        int          count;
        int          idx;
        logic [63:0] v;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: eight rounds, zero key and constant
        queue_block('0, '0, '0, '0);
        queue_block('1, '1, '1, '1);
        for (k = 0; k < 16; k++)
            queue_block({8{k[3:0]}}, {8{k[3:0]}}, {8{k[3:0]}}, {8{k[3:0]}});
        queue_block(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        wait_idle();

        // writes to unused indexes must leave everything as it was
        for (idx = nsbe_pkg::REG_ROUNDS + 1; idx < (1 << nsbe_pkg::IDX_W); idx++)
            write_reg(nsbe_pkg::IDX_W'(idx), '1);
        end_writes();
        queue_random(10);
        wait_idle();

        // zero rounds passes the block straight through
        write_reg(nsbe_pkg::REG_KEY_LOW, rand_reg());
        write_reg(nsbe_pkg::REG_KEY_HIGH, rand_reg());
        write_reg(nsbe_pkg::REG_CONST_LOW, rand_reg());
        write_reg(nsbe_pkg::REG_CONST_HIGH, rand_reg());
        write_reg(nsbe_pkg::REG_ROUNDS, '0);
        end_writes();
        queue_block('0, '0, '0, '0);
        queue_block('1, '1, '1, '1);
        queue_random(28);
        wait_idle();

        write_reg(nsbe_pkg::REG_KEY_LOW, '1);
        write_reg(nsbe_pkg::REG_KEY_HIGH, '1);
        write_reg(nsbe_pkg::REG_CONST_LOW, '1);
        write_reg(nsbe_pkg::REG_CONST_HIGH, '1);
        write_reg(nsbe_pkg::REG_ROUNDS, 64'd1);
        end_writes();
        queue_block('0, '0, '0, '0);
        queue_block('1, '1, '1, '1);
        queue_random(38);
        wait_idle();

        // only the low byte of a wide value counts
        write_reg(nsbe_pkg::REG_KEY_LOW, {$urandom, $urandom});
        write_reg(nsbe_pkg::REG_CONST_HIGH, '0);
        write_reg(nsbe_pkg::REG_ROUNDS, 64'hFFFF_FFFF_FFFF_FF03);
        end_writes();
        queue_random(40);
        wait_idle();

        write_reg(nsbe_pkg::REG_ROUNDS, 64'hFF);
        end_writes();
        queue_block('1, '1, '1, '1);
        queue_random(7);
        wait_idle();

        for (p = 0; p < 12; p++)
        begin
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            write_reg(nsbe_pkg::REG_KEY_LOW, rand_reg());
            write_reg(nsbe_pkg::REG_KEY_HIGH, rand_reg());
            write_reg(nsbe_pkg::REG_CONST_LOW, rand_reg());
            write_reg(nsbe_pkg::REG_CONST_HIGH, rand_reg());
            v = {$urandom, $urandom};
            if ($urandom_range(0, 7) == 0)
                v[nsbe_pkg::ROUND_W-1:0] = nsbe_pkg::ROUND_W'($urandom_range(0, 255));
            else
                v[nsbe_pkg::ROUND_W-1:0] = nsbe_pkg::ROUND_W'($urandom_range(1, 16));
            write_reg(nsbe_pkg::REG_ROUNDS, v);
            if ($urandom_range(0, 3) == 0)
                write_reg(nsbe_pkg::IDX_W'($urandom_range(nsbe_pkg::REG_ROUNDS + 1,
                                                          (1 << nsbe_pkg::IDX_W) - 1)),
                          {$urandom, $urandom});
            end_writes();
            count = $urandom_range(70, 90);
            if (p == 5)
            begin
                // sender holds off until the block has drained
                queue_random(count / 2);
                wait_idle();
                queue_random(count - count / 2);
            end
            else
                queue_random(count);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ nibble_spn_block_encrypt.f @@
hdl/nsbe_pkg.sv
hdl/nsbe_cfg.sv
hdl/nsbe_round.sv
hdl/nibble_spn_block_encrypt.sv
hdl/nsbe_checker.sv
tb/sv/tb.sv
